>>> src/glu_pkg.sv
// Package for the gcd/lcm unit: operand width, sequencer states and word types.
// Used by glu_alu and gcd_lcm_unit; depends on nothing else.
`default_nettype none
package glu_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int CNT_W         = $clog2(OPERAND_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_REDUCE,
    ST_DIV,
    ST_MUL
  } glu_state_t;

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] a_value;
    logic [OPERAND_WIDTH-1:0] b_value;
  } glu_in_t;

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] gcd_result;
    logic [OPERAND_WIDTH-1:0] lcm_result;
    logic                     lcm_overflow;
  } glu_out_t;

endpackage
`default_nettype wire

>>> src/glu_alu.sv
// Shared adder/subtractor of the gcd/lcm unit, one operand width plus one bit.
// Depends on glu_pkg for the default width.
`default_nettype none
module glu_alu
  import glu_pkg::*;
#(
  parameter int WIDTH = OPERAND_WIDTH
) (
  input  wire logic [WIDTH:0] op_a,
  input  wire logic [WIDTH:0] op_b,
  input  wire logic           sub,
  output logic      [WIDTH:0] sum,
  output logic                carry
);

  logic [WIDTH+1:0] full;

  // Add, or subtract as a plus inverted plus one; carry out means a >= b on subtract
  assign full  = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {{(WIDTH+1){1'b0}}, sub};
  assign sum   = full[WIDTH:0];
  assign carry = full[WIDTH+1];

endmodule
`default_nettype wire

>>> src/gcd_lcm_unit.sv
// Top level of the gcd/lcm unit: sequencer around one shared adder/subtractor.
// Depends on glu_pkg and glu_alu.
//
//  channel  ports                   handshake
//  input    start, busy, in_word    taken at an edge with start high and busy low
//  result   out_valid, out_word     one-cycle strobe, always taken
//
// One word runs one binary-gcd step per cycle (align shifts, halvings, subtracts and
// swaps), then restoring division a/gcd and shift-add multiply, all on the one
// adder/subtractor.
// A zero operand ends in the align state. busy stays high until the result strobe.
// Reset is synchronous and active low; it clears the state and the strobe.
// The receiver cannot stall: out_valid lasts one cycle, and the next word may be
// taken in that same cycle.
`default_nettype none
module gcd_lcm_unit
  import glu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire glu_in_t  in_word,
  output logic          out_valid,
  output glu_out_t      out_word
);

  localparam int W = OPERAND_WIDTH;

  glu_state_t     state_r, state_nxt;
  logic [W-1:0]   x_r, x_nxt;
  logic [W-1:0]   y_r, y_nxt;
  logic [W-1:0]   a_r, a_nxt;     // dividend, then quotient, then product low half
  logic [W-1:0]   b_r, b_nxt;
  logic [W-1:0]   g_r, g_nxt;
  logic [W-1:0]   acc_r, acc_nxt; // remainder, then product high half
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  glu_out_t       out_word_r, out_word_nxt;

  logic [W:0]     alu_a, alu_b, alu_sum;
  logic           alu_sub, alu_carry;
  logic [W:0]     trial;
  logic [W:0]     mul_s;
  logic           last_step;

  glu_alu #(.WIDTH(W)) u_alu (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign trial     = {acc_r, a_r[W-1]};
  assign last_step = (cnt_r == CNT_W'(W - 1));
  assign mul_s     = a_r[0] ? alu_sum : {1'b0, acc_r};

  // Route operands to the shared unit for the current step
  always_comb begin
    alu_a   = {1'b0, x_r};
    alu_b   = {1'b0, y_r};
    alu_sub = 1'b1;
    case (state_r)
      ST_DIV: begin
        alu_a = trial;
        alu_b = {1'b0, g_r};
      end
      ST_MUL: begin
        alu_a   = {1'b0, acc_r};
        alu_b   = {1'b0, b_r};
        alu_sub = 1'b0;
      end
      default: begin
        alu_a = {1'b0, x_r};
        alu_b = {1'b0, y_r};
      end
    endcase
  end

  // Sequencer: next state and next register values
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    g_nxt         = g_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_nxt     = in_word.a_value;
          y_nxt     = in_word.b_value;
          a_nxt     = in_word.a_value;
          b_nxt     = in_word.b_value;
          k_nxt     = '0;
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (x_r == '0 || y_r == '0) begin
          // zero operand: gcd is the other one, no lcm
          out_word_nxt.gcd_result   = x_r | y_r;
          out_word_nxt.lcm_result   = '0;
          out_word_nxt.lcm_overflow = 1'b0;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end else if (!x_r[0] && !y_r[0]) begin
          // strip a common factor of two
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (x_r == '0 || y_r == '0) begin
          g_nxt     = (x_r | y_r) << k_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (alu_carry) begin
          // both odd, x >= y: difference is even
          x_nxt = alu_sum[W:1];
        end else begin
          // both odd, x < y: swap and subtract next cycle
          x_nxt = y_r;
          y_nxt = x_r;
        end
      end
      ST_DIV: begin
        // restoring division step: quotient bit shifts into a
        acc_nxt = alu_carry ? alu_sum[W-1:0] : trial[W-1:0];
        a_nxt   = {a_r[W-2:0], alu_carry};
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // shift-add step: add b when the low multiplier bit is set, then shift right
        acc_nxt = mul_s[W:1];
        a_nxt   = {mul_s[0], a_r[W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          out_word_nxt.gcd_result   = g_r;
          out_word_nxt.lcm_result   = {mul_s[0], a_r[W-1:1]};
          out_word_nxt.lcm_overflow = (mul_s[W:1] != '0);
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    g_r        <= g_nxt;
    acc_r      <= acc_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    out_word_r <= out_word_nxt;
  end

  // An accepted word keeps the unit busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // A result only follows a cycle of work
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  // gcd is zero only when both operands were zero, which gives no lcm
  a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.gcd_result == '0) |->
      (out_word.lcm_result == '0 && !out_word.lcm_overflow))
    else $error("zero gcd with nonzero lcm");

  // Strobe lasts one cycle and the unit is idle when it shows
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) != ST_IDLE) && (state_r == ST_IDLE))
    else $error("result strobe outside the end of an item");

endmodule
`default_nettype wire

>>> tb/sv/gcd_lcm_unit_test.sv
// Self-checking testbench for gcd_lcm_unit: directed corner words, then random operand pairs.
// Depends on glu_pkg and the gcd_lcm_unit RTL; predicts gcd, wrapped lcm and overflow per word.
`timescale 1ns / 1ps
module gcd_lcm_unit_test;
  import glu_pkg::*;

  localparam int W          = OPERAND_WIDTH;
  localparam int N_RANDOM   = 750;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 200;
  localparam logic [W-1:0] ALL_ONES = '1;
  localparam logic [W-1:0] TOP_BIT  = {1'b1, {(W-1){1'b0}}};

  typedef struct {
    logic [W-1:0] a;
    logic [W-1:0] b;
    bit           typed;
    glu_out_t     want;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  glu_in_t  in_word;
  logic     out_valid;
  glu_out_t out_word;

  glu_out_t gcd_lcm_due[$];
  dir_row_t dir_rows[$];
  int       fail_count;
  int       idle_cycles;
  int       no_gap_left;

  gcd_lcm_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Euclid remainder loop, then lcm as (a / gcd) * b on a double-width product
  function automatic glu_out_t gcd_lcm_of(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W-1:0]   x;
    logic [W-1:0]   y;
    logic [W-1:0]   r;
    logic [W-1:0]   q;
    logic [2*W-1:0] prod;
    glu_out_t       res;
    x = a;
    y = b;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    res = '0;
    res.gcd_result = x;
    if (a != '0 && b != '0) begin
      q = a / x;
      prod = {{W{1'b0}}, q} * {{W{1'b0}}, b};
      res.lcm_result   = prod[W-1:0];
      res.lcm_overflow = |prod[2*W-1:W];
    end
    return res;
  endfunction

  function automatic dir_row_t row(input logic [W-1:0] a, input logic [W-1:0] b,
                                   input bit typed, input logic [W-1:0] g,
                                   input logic [W-1:0] l, input logic o);
    dir_row_t t;
    t.a = a;
    t.b = b;
    t.typed = typed;
    t.want.gcd_result   = g;
    t.want.lcm_result   = l;
    t.want.lcm_overflow = o;
    return t;
  endfunction

  // Draw an operand pair from a few shapes: raw, shared factor, small, one zero, shifted small, right-shifted copy
  function automatic glu_in_t random_pair();
    glu_in_t      w;
    logic [W-1:0] g;
    logic [W-1:0] t;
    w = '0;
    case ($urandom_range(0, 5))
      0: begin
        w.a_value = $urandom;
        w.b_value = $urandom;
      end
      1: begin
        g = $urandom_range(1, 65535);
        w.a_value = g * $urandom_range(1, 65535);
        w.b_value = g * $urandom_range(1, 65535);
      end
      2: begin
        w.a_value = $urandom_range(0, 255);
        w.b_value = $urandom_range(0, 255);
      end
      3: begin
        w.a_value = ($urandom_range(0, 1) != 0) ? W'($urandom) : '0;
        w.b_value = (w.a_value == '0) ? W'($urandom) : '0;
      end
      4: begin
        w.a_value = W'($urandom_range(1, 255)) << $urandom_range(0, 24);
        w.b_value = W'($urandom_range(1, 255)) << $urandom_range(0, 24);
      end
      default: begin
        w.a_value = $urandom;
        w.b_value = w.a_value >> $urandom_range(0, W - 1);
      end
    endcase
    if ($urandom_range(0, 1) != 0) begin
      t = w.a_value;
      w.a_value = w.b_value;
      w.b_value = t;
    end
    return w;
  endfunction

  // Present one word after a random gap, hold until taken, queue its expectation
  task automatic send_word(input glu_in_t w, input glu_out_t want);
    int gap;
    if (no_gap_left > 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 40) == 0)
        no_gap_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    gcd_lcm_due.push_back(want);
    @(negedge clk);
  endtask

  // Check each result strobe against the oldest expectation
  always @(posedge clk) begin
    glu_out_t want;
    if (rst_n && out_valid) begin
      if (gcd_lcm_due.size() == 0) begin
        $error("unexpected result word: gcd %0h lcm %0h ovf %0b",
               out_word.gcd_result, out_word.lcm_result, out_word.lcm_overflow);
        fail_count++;
      end else begin
        want = gcd_lcm_due.pop_front();
        if (out_word.gcd_result !== want.gcd_result) begin
          $error("gcd_result: expected %0h, got %0h", want.gcd_result, out_word.gcd_result);
          fail_count++;
        end
        if (out_word.lcm_result !== want.lcm_result) begin
          $error("lcm_result: expected %0h, got %0h", want.lcm_result, out_word.lcm_result);
          fail_count++;
        end
        if (out_word.lcm_overflow !== want.lcm_overflow) begin
          $error("lcm_overflow: expected %0b, got %0b", want.lcm_overflow,
                 out_word.lcm_overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count edges where no word moves in either direction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("gcd_lcm_unit: mismatch");
      $finish;
    end
  end

  initial begin
    glu_in_t w;
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_word     = '0;
    fail_count  = 0;
    idle_cycles = 0;
    no_gap_left = 0;

    // Corner words; typed expectations where the answer is obvious
    dir_rows.push_back(row('0, '0, 1, '0, '0, 1'b0));
    dir_rows.push_back(row('0, ALL_ONES, 1, ALL_ONES, '0, 1'b0));
    dir_rows.push_back(row(ALL_ONES, '0, 1, ALL_ONES, '0, 1'b0));
    dir_rows.push_back(row(32'd7, '0, 1, 32'd7, '0, 1'b0));
    dir_rows.push_back(row('0, 32'd1, 1, 32'd1, '0, 1'b0));
    dir_rows.push_back(row(32'd1, 32'd1, 1, 32'd1, 32'd1, 1'b0));
    dir_rows.push_back(row(ALL_ONES, ALL_ONES, 1, ALL_ONES, ALL_ONES, 1'b0));
    dir_rows.push_back(row(32'd1, ALL_ONES, 1, 32'd1, ALL_ONES, 1'b0));
    dir_rows.push_back(row(ALL_ONES, 32'd1, 1, 32'd1, ALL_ONES, 1'b0));
    dir_rows.push_back(row(TOP_BIT, TOP_BIT, 1, TOP_BIT, TOP_BIT, 1'b0));
    dir_rows.push_back(row(TOP_BIT, 32'd3, 1, 32'd1, TOP_BIT, 1'b1));
    dir_rows.push_back(row(32'h0001_0000, 32'h0001_0001, 1, 32'd1, 32'h0001_0000, 1'b1));
    dir_rows.push_back(row(32'd12, 32'd18, 1, 32'd6, 32'd36, 1'b0));
    dir_rows.push_back(row(32'hFFFF_FFFE, ALL_ONES, 0, '0, '0, 1'b0));
    dir_rows.push_back(row(32'hAAAA_AAAA, 32'h5555_5555, 0, '0, '0, 1'b0));
    dir_rows.push_back(row(32'd2971215073, 32'd1836311903, 0, '0, '0, 1'b0));
    dir_rows.push_back(row(32'h4000_0000, 32'h0000_C000, 0, '0, '0, 1'b0));
    dir_rows.push_back(row(32'h0000_FFFF, 32'h0001_0001, 0, '0, '0, 1'b0));
    dir_rows.push_back(row(32'h0001_0000, 32'h0001_0000, 0, '0, '0, 1'b0));
    dir_rows.push_back(row(32'd65536, 32'd65535, 0, '0, '0, 1'b0));
    dir_rows.push_back(row(32'h8000_0001, 32'h7FFF_FFFF, 0, '0, '0, 1'b0));

    // Hold reset, then release it on a falling edge
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      w.a_value = dir_rows[i].a;
      w.b_value = dir_rows[i].b;
      send_word(w, dir_rows[i].typed ? dir_rows[i].want : gcd_lcm_of(w.a_value, w.b_value));
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      w = random_pair();
      send_word(w, gcd_lcm_of(w.a_value, w.b_value));
    end
    start <= 1'b0;

    // Drain, then watch a while longer for stray strobes
    while (gcd_lcm_due.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (fail_count == 0)
      $display("gcd_lcm_unit: match");
    else
      $display("gcd_lcm_unit: mismatch");
    $finish;
  end

endmodule

>>> sim.f
src/glu_pkg.sv
src/glu_alu.sv
src/gcd_lcm_unit.sv
tb/sv/gcd_lcm_unit_test.sv
